/* hw/rtl/lmbp_pkg.sv */
// Shared types and constants of the latest-message buffer pool.
`default_nettype none

package lmbp_pkg;

  // Default sizing of the pool
  localparam int DEF_NUM_BUFFERS = 8;
  localparam int DEF_MAX_WORDS   = 16;
  localparam int DEF_MAX_READERS = 255;

  // Fixed field widths
  localparam int WORD_BITS   = 32;
  localparam int OP_W        = 2;
  localparam int BUF_W       = 3;
  localparam int WIDX_W      = 4;
  localparam int SIZE_W      = 5;
  localparam int COUNT_OUT_W = 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_PUBLISH = 2'd1,
    OP_GET     = 2'd2,
    OP_UNGET   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_LIMIT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_STREAM
  } back_state_e;

  typedef struct packed {
    op_e                  op;
    logic [BUF_W-1:0]     buffer_index;
    logic [WIDX_W-1:0]    word_index;
    logic [WORD_BITS-1:0] data_word;
    logic                 final_word;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [BUF_W-1:0]       granted_buffer;
    logic [WORD_BITS-1:0]   read_word;
    logic                   last_result;
    logic [COUNT_OUT_W-1:0] reader_count;
  } res_t;

  // Classified request as held in the queue
  typedef struct packed {
    op_e                  op;
    logic [BUF_W-1:0]     buffer_index;
    logic                 bad_index;
    logic [WIDX_W-1:0]    word_index;
    logic                 word_ok;
    logic [WORD_BITS-1:0] data_word;
    logic                 final_word;
  } qitem_t;

endpackage

`default_nettype wire

/* hw/rtl/lmbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lmbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/lmbp_fifo.sv */
// Two-entry queue of classified requests between front and back.
`default_nettype none

module lmbp_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire lmbp_pkg::qitem_t item_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output lmbp_pkg::qitem_t     item_o
);

  import lmbp_pkg::*;

  qitem_t     slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign item_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lmbp_front.sv */
// Front end: request acceptance, size register and classification.
`default_nettype none

module lmbp_front #(
  parameter int NUM_BUFFERS = lmbp_pkg::DEF_NUM_BUFFERS,
  parameter int MAX_WORDS   = lmbp_pkg::DEF_MAX_WORDS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire lmbp_pkg::req_t                req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [lmbp_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  wire logic                          q_full_i,
  input  wire logic                          clearing_i,
  output logic                               q_push_o,
  output lmbp_pkg::qitem_t                   q_item_o,
  output logic [$clog2(MAX_WORDS+1)-1:0]     eff_size_o
);

  import lmbp_pkg::*;

  localparam int WC_W = $clog2(MAX_WORDS + 1);

  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Clamp the size register into 1..MAX_WORDS
  always_comb begin
    if (size_q == '0) begin
      eff_size_o = WC_W'(1);
    end else if (32'(size_q) > 32'(MAX_WORDS)) begin
      eff_size_o = WC_W'(MAX_WORDS);
    end else begin
      eff_size_o = WC_W'(size_q);
    end
  end

  assign busy     = q_full_i | clearing_i;
  assign q_push_o = start & ~busy;

  always_comb begin
    q_item_o.op           = req_i.op;
    q_item_o.buffer_index = req_i.buffer_index;
    q_item_o.bad_index    = (32'(req_i.buffer_index) >= 32'(NUM_BUFFERS));
    q_item_o.word_index   = req_i.word_index;
    q_item_o.word_ok      = (32'(req_i.word_index) < 32'(eff_size_o));
    q_item_o.data_word    = req_i.data_word;
    q_item_o.final_word   = req_i.final_word;
  end

endmodule

`default_nettype wire

/* hw/rtl/lmbp_back.sv */
// Back end: buffer tables, payload writes, result register and get streaming.
`default_nettype none

module lmbp_back #(
  parameter int NUM_BUFFERS = lmbp_pkg::DEF_NUM_BUFFERS,
  parameter int MAX_WORDS   = lmbp_pkg::DEF_MAX_WORDS,
  parameter int MAX_READERS = lmbp_pkg::DEF_MAX_READERS,
  localparam int IDX_W      = $clog2(NUM_BUFFERS),
  localparam int WI_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int ADDR_W     = IDX_W + WI_W,
  localparam int WC_W       = $clog2(MAX_WORDS + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_empty_i,
  input  wire lmbp_pkg::qitem_t                q_item_i,
  output logic                                 q_pop_o,
  input  wire logic [WC_W-1:0]                 eff_size_i,
  output logic                                 clearing_o,
  output logic                                 ram_we_o,
  output logic [ADDR_W-1:0]                    ram_waddr_o,
  output logic [lmbp_pkg::WORD_BITS-1:0]       ram_wdata_o,
  output logic [ADDR_W-1:0]                    ram_raddr_o,
  input  wire logic [lmbp_pkg::WORD_BITS-1:0]  ram_rdata_i,
  output logic                                 res_valid_o,
  output lmbp_pkg::res_t                       res_o
);

  import lmbp_pkg::*;

  localparam int CNT_W     = $clog2(MAX_READERS + 1);
  localparam int RAM_DEPTH = NUM_BUFFERS * (2 ** WI_W);

  back_state_e             state_q, state_d;
  logic [CNT_W-1:0]        cnt_q [NUM_BUFFERS];
  logic [CNT_W-1:0]        cnt_d [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]  rsv_q, rsv_d;
  logic [NUM_BUFFERS-1:0]  alloc_q, alloc_d;
  logic [IDX_W-1:0]        cur_q, cur_d;
  logic                    cur_valid_q, cur_valid_d;
  logic [WI_W-1:0]         k_q, k_d;
  logic [ADDR_W-1:0]       clr_q, clr_d;
  logic                    res_valid_q, res_valid_d;
  res_t                    res_q, res_d;

  logic [IDX_W-1:0]        b;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic [CNT_W-1:0]        left;
  logic [WC_W-1:0]         kp1;
  logic                    stream_valid;
  res_t                    stream_res;

  assign b          = IDX_W'(q_item_i.buffer_index);
  assign left       = cnt_q[b] - CNT_W'(1);
  assign kp1        = WC_W'(k_q) + WC_W'(1);
  assign clearing_o = (state_q == BK_CLEAR);

  // Lowest free buffer
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rsv_d        = rsv_q;
    alloc_d      = alloc_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    k_d          = k_q;
    clr_d        = clr_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    q_pop_o      = 1'b0;
    ram_we_o     = 1'b0;
    ram_waddr_o  = {b, WI_W'(q_item_i.word_index)};
    ram_wdata_o  = q_item_i.data_word;
    ram_raddr_o  = {cur_q, k_q};
    stream_valid = 1'b0;
    stream_res   = '0;

    unique case (state_q)
      BK_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        if (clr_q == ADDR_W'(RAM_DEPTH - 1)) begin
          state_d = BK_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end

      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o                    = 1'b1;
          res_valid_d                = 1'b1;
          res_d.status               = ST_OK;
          res_d.granted_buffer       = q_item_i.buffer_index;
          res_d.read_word            = '0;
          res_d.last_result          = 1'b1;
          res_d.reader_count         = '0;
          unique case (q_item_i.op)
            OP_RESERVE: begin
              if (cur_valid_q && cnt_q[cur_q] == '0 && !rsv_q[cur_q]) begin
                rsv_d[cur_q]         = 1'b1;
                res_d.granted_buffer = BUF_W'(cur_q);
              end else if (free_found) begin
                alloc_d[free_idx]    = 1'b1;
                rsv_d[free_idx]      = 1'b1;
                cnt_d[free_idx]      = '0;
                res_d.granted_buffer = BUF_W'(free_idx);
              end else begin
                res_d.status         = ST_EMPTY;
                res_d.granted_buffer = '0;
              end
            end

            OP_PUBLISH: begin
              if (q_item_i.bad_index || !alloc_q[b] || cnt_q[b] != '0 || !rsv_q[b]) begin
                res_d.status       = ST_BAD;
                res_d.reader_count = q_item_i.bad_index ? '0 : COUNT_OUT_W'(cnt_q[b]);
              end else begin
                ram_we_o = q_item_i.word_ok;
                if (q_item_i.final_word) begin
                  // Drop an unused previous current buffer
                  if (cur_valid_q && cur_q != b && cnt_q[cur_q] == '0 && !rsv_q[cur_q]) begin
                    rsv_d[cur_q]   = 1'b0;
                    alloc_d[cur_q] = 1'b0;
                    cnt_d[cur_q]   = '0;
                  end
                  rsv_d[b]    = 1'b0;
                  cur_d       = b;
                  cur_valid_d = 1'b1;
                end
                res_d.reader_count = COUNT_OUT_W'(cnt_q[b]);
              end
            end

            OP_GET: begin
              res_d.granted_buffer = BUF_W'(cur_q);
              if (!cur_valid_q || rsv_q[cur_q]) begin
                res_d.status         = ST_EMPTY;
                res_d.granted_buffer = '0;
              end else if (32'(cnt_q[cur_q]) >= 32'(MAX_READERS)) begin
                res_d.status       = ST_LIMIT;
                res_d.reader_count = COUNT_OUT_W'(cnt_q[cur_q]);
              end else begin
                res_valid_d  = 1'b0;
                cnt_d[cur_q] = cnt_q[cur_q] + CNT_W'(1);
                k_d          = '0;
                ram_raddr_o  = {cur_q, WI_W'(0)};
                state_d      = BK_STREAM;
              end
            end

            OP_UNGET: begin
              if (q_item_i.bad_index || !alloc_q[b] || cnt_q[b] == '0) begin
                res_d.status       = ST_BAD;
                res_d.reader_count = q_item_i.bad_index ? '0 : COUNT_OUT_W'(cnt_q[b]);
              end else begin
                cnt_d[b] = left;
                if (left == '0 && !(cur_valid_q && cur_q == b)) begin
                  rsv_d[b]   = 1'b0;
                  alloc_d[b] = 1'b0;
                end
                res_d.reader_count = COUNT_OUT_W'(left);
              end
            end
          endcase
        end
      end

      BK_STREAM: begin
        // Word k_q is in the read register; fetch the next one
        stream_valid              = 1'b1;
        stream_res.status         = ST_OK;
        stream_res.granted_buffer = BUF_W'(cur_q);
        stream_res.read_word      = ram_rdata_i;
        stream_res.last_result    = (kp1 == eff_size_i);
        stream_res.reader_count   = COUNT_OUT_W'(cnt_q[cur_q]);
        ram_raddr_o               = {cur_q, WI_W'(kp1)};
        if (kp1 == eff_size_i) begin
          state_d = BK_IDLE;
        end else begin
          k_d = WI_W'(kp1);
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        cnt_q[i] <= '0;
      end
      rsv_q       <= '0;
      alloc_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      k_q         <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rsv_q       <= rsv_d;
      alloc_q     <= alloc_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      k_q         <= k_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q | stream_valid;
  assign res_o       = stream_valid ? stream_res : res_q;

endmodule

`default_nettype wire

/* hw/rtl/latest_message_buffer_pool.sv */
// Top level of the latest-message buffer pool: front, request queue, back and payload RAM.
//
//   channel   | ports                        | handshake
//   ----------+------------------------------+----------------------------------------
//   request   | start, busy, req_i           | taken when start is high and busy low
//   result    | res_valid_o, res_o           | each result valid for a single cycle, cannot be held off
//   size reg  | cfg_we_i, cfg_wdata_i        | written on any edge with cfg_we_i high
//
// A request goes into a two-entry queue in its accept cycle; the back end takes
// it from the queue, when idle, once the registered fill count shows it there.
// Reserve, publish, unget and a refused get give their single result from the
// result register in the cycle after the back end takes them. A successful get
// first bumps the reader count and starts the payload read, then gives one result
// per payload word from the RAM read port. Meanwhile further requests collect in
// the queue; busy rises when it is full. After reset the back end zeroes all
// NUM_BUFFERS * 2**WI_W words of the payload RAM (128 at the defaults), one word
// a cycle, holding busy high.
// The receiver cannot stall, so results never wait.
`default_nettype none

module latest_message_buffer_pool #(
  parameter int NUM_BUFFERS = lmbp_pkg::DEF_NUM_BUFFERS,
  parameter int MAX_WORDS   = lmbp_pkg::DEF_MAX_WORDS,
  parameter int MAX_READERS = lmbp_pkg::DEF_MAX_READERS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lmbp_pkg::req_t              req_i,
  output logic                             res_valid_o,
  output lmbp_pkg::res_t                   res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [lmbp_pkg::SIZE_W-1:0] cfg_wdata_i
);

  import lmbp_pkg::*;

  localparam int IDX_W     = $clog2(NUM_BUFFERS);
  localparam int WI_W      = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int ADDR_W    = IDX_W + WI_W;
  localparam int WC_W      = $clog2(MAX_WORDS + 1);
  localparam int RAM_DEPTH = NUM_BUFFERS * (2 ** WI_W);

  // Front to queue
  logic              q_push;
  qitem_t            q_in;
  logic              q_full;
  // Queue to back
  logic              q_empty;
  logic              q_pop;
  qitem_t            q_out;
  // Shared status
  logic [WC_W-1:0]   eff_size;
  logic              clearing;
  // Payload RAM
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Accept and classify requests, hold the size register
  lmbp_front #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .MAX_WORDS   (MAX_WORDS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .q_push_o    (q_push),
    .q_item_o    (q_in),
    .eff_size_o  (eff_size)
  );

  // Decouple acceptance from execution
  lmbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (q_pop),
    .item_o  (q_out)
  );

  // Execute against the buffer tables and stream payloads
  lmbp_back #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .MAX_WORDS   (MAX_WORDS),
    .MAX_READERS (MAX_READERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .eff_size_i  (eff_size),
    .clearing_o  (clearing),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Payload words, one row of 2**WI_W words per buffer
  lmbp_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
